[src/t3mm_pkg.sv]
package t3mm_pkg;

    localparam int COUNT_BITS = 16;
    localparam int BAR_BITS = 16;
    localparam int LIMIT_BITS = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd112;
    localparam int LOW_RESET = 9999;

    // Smallest signed width that holds the reset value of the smallest values.
    localparam int LOW_MIN_BITS = 15;

    typedef enum logic [1:0] {
        CLS_VALID    = 2'd0,
        CLS_NEGATIVE = 2'd1,
        CLS_ABOVE    = 2'd2,
        CLS_ZERO     = 2'd3
    } t_sample_class;

endpackage

[src/t3mm_cfg_if.sv]
interface t3mm_cfg_if;
    import t3mm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LIMIT_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/t3mm_sample_if.sv]
interface t3mm_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[src/t3mm_result_if.sv]
interface t3mm_result_if #(
    parameter int SAMPLE_BITS = 16
);
    import t3mm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [COUNT_BITS-1:0]         sample_index;
    logic [BAR_BITS-1:0]           bar_length;
    t_sample_class                 sample_class;
    logic signed [SAMPLE_BITS-1:0] largest_first;
    logic signed [SAMPLE_BITS-1:0] largest_second;
    logic signed [SAMPLE_BITS-1:0] largest_third;
    logic signed [SAMPLE_BITS-1:0] smallest_first;
    logic signed [SAMPLE_BITS-1:0] smallest_second;
    logic signed [SAMPLE_BITS-1:0] smallest_third;
    logic [COUNT_BITS-1:0]         invalid_total;

    modport source (
        output valid, output sample_index, output bar_length, output sample_class,
        output largest_first, output largest_second, output largest_third,
        output smallest_first, output smallest_second, output smallest_third,
        output invalid_total, input ready
    );
    modport sink (
        input valid, input sample_index, input bar_length, input sample_class,
        input largest_first, input largest_second, input largest_third,
        input smallest_first, input smallest_second, input smallest_third,
        input invalid_total, output ready
    );
endinterface

[src/top3_min_max_tracker_top.sv]
// Running tracker of the three largest and three smallest samples of a stream.
// Samples arrive on i_sample as valid/ready requests; every accepted sample
// yields exactly one result request on o_result with its index, bar length,
// class, the six running extremes and the count of invalid samples.
// The result of a sample is registered at the edge that accepts it.
// Throughput is one sample per cycle while the receiver takes results, set by
// the single compare-and-update stage that feeds the result register.
// i_sample.ready is high while the result register is empty or being read,
// so a stalled receiver holds the current result and stops further samples.
// The bar limit is written on i_cfg, which is always ready; write it only
// while no result is pending.
// Reset clears the counters, sets the largest values to 0, the smallest
// values to 9999 and the bar limit to 112, and empties the result register.
module top3_min_max_tracker_top #(
    parameter int SAMPLE_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    t3mm_cfg_if.sink      i_cfg,
    t3mm_sample_if.sink   i_sample,
    t3mm_result_if.source o_result
);
    import t3mm_pkg::*;

    localparam int LW = (SAMPLE_BITS > LOW_MIN_BITS) ? SAMPLE_BITS : LOW_MIN_BITS;
    localparam int MW = (SAMPLE_BITS + 1 > BAR_BITS) ? SAMPLE_BITS + 1 : BAR_BITS;

    logic [LIMIT_BITS-1:0]  r_bar_limit;
    logic signed [LW-1:0]   r_big_one, r_big_two, r_big_three;
    logic signed [LW-1:0]   r_low_one, r_low_two, r_low_three;
    logic [COUNT_BITS-1:0]  r_seen, r_bad;
    logic                   r_out_valid;
    logic [BAR_BITS-1:0]    r_bar;
    t_sample_class          r_class;

    logic signed [LW-1:0]   n_big_one, n_big_two, n_big_three;
    logic signed [LW-1:0]   n_low_one, n_low_two, n_low_three;
    logic [COUNT_BITS-1:0]  n_seen, n_bad;
    logic [BAR_BITS-1:0]    n_bar;
    t_sample_class          n_class;

    logic                   w_accept;
    logic signed [LW-1:0]   w_s;
    logic signed [LW-1:0]   w_limit;
    logic signed [MW-1:0]   w_sx;
    logic signed [MW-1:0]   w_neg;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign w_accept       = i_sample.valid && i_sample.ready;

    assign w_s     = LW'(i_sample.sample);
    assign w_limit = LW'($signed({1'b0, r_bar_limit}));
    assign w_sx    = MW'(i_sample.sample);
    assign w_neg   = -w_sx;

    always_comb begin
        n_seen = (r_seen == COUNT_MAX) ? r_seen : r_seen + 1'b1;
        n_bad  = r_bad;

        n_big_one   = r_big_one;
        n_big_two   = r_big_two;
        n_big_three = r_big_three;
        if (w_s > r_big_one) begin
            n_big_three = r_big_two;
            n_big_two   = r_big_one;
            n_big_one   = w_s;
        end else if (w_s > r_big_two) begin
            n_big_three = r_big_two;
            n_big_two   = w_s;
        end else if (w_s > r_big_three) begin
            n_big_three = w_s;
        end

        n_low_one   = r_low_one;
        n_low_two   = r_low_two;
        n_low_three = r_low_three;
        if (w_s < r_low_one) begin
            n_low_three = r_low_two;
            n_low_two   = r_low_one;
            n_low_one   = w_s;
        end else if (w_s < r_low_two) begin
            n_low_three = r_low_two;
            n_low_two   = w_s;
        end else if (w_s < r_low_three) begin
            n_low_three = w_s;
        end

        if (w_s > 0 && w_s <= w_limit) begin
            n_class = CLS_VALID;
            n_bar   = {{(BAR_BITS-LIMIT_BITS){1'b0}}, w_s[LIMIT_BITS-1:0]};
        end else if (w_s < 0) begin
            n_class = CLS_NEGATIVE;
            n_bar   = w_neg[BAR_BITS-1:0];
            if (r_bad != COUNT_MAX) begin
                n_bad = r_bad + 1'b1;
            end
        end else if (w_s > w_limit) begin
            n_class = CLS_ABOVE;
            n_bar   = {{(BAR_BITS-LIMIT_BITS){1'b0}}, r_bar_limit};
            if (r_bad != COUNT_MAX) begin
                n_bad = r_bad + 1'b1;
            end
        end else begin
            n_class = CLS_ZERO;
            n_bar   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_limit <= LIMIT_RESET;
            r_big_one   <= '0;
            r_big_two   <= '0;
            r_big_three <= '0;
            r_low_one   <= LW'(LOW_RESET);
            r_low_two   <= LW'(LOW_RESET);
            r_low_three <= LW'(LOW_RESET);
            r_seen      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_bar_limit <= i_cfg.data;
            end
            if (w_accept) begin
                r_big_one   <= n_big_one;
                r_big_two   <= n_big_two;
                r_big_three <= n_big_three;
                r_low_one   <= n_low_one;
                r_low_two   <= n_low_two;
                r_low_three <= n_low_three;
                r_seen      <= n_seen;
                r_bad       <= n_bad;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bar   <= n_bar;
            r_class <= n_class;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.sample_index    = r_seen;
    assign o_result.bar_length      = r_bar;
    assign o_result.sample_class    = r_class;
    assign o_result.largest_first   = r_big_one[SAMPLE_BITS-1:0];
    assign o_result.largest_second  = r_big_two[SAMPLE_BITS-1:0];
    assign o_result.largest_third   = r_big_three[SAMPLE_BITS-1:0];
    assign o_result.smallest_first  = r_low_one[SAMPLE_BITS-1:0];
    assign o_result.smallest_second = r_low_two[SAMPLE_BITS-1:0];
    assign o_result.smallest_third  = r_low_three[SAMPLE_BITS-1:0];
    assign o_result.invalid_total   = r_bad;

endmodule

[sim/top3_min_max_tracker_top_test.sv]
import t3mm_pkg::*;

typedef logic signed [15:0] t_sample;

typedef struct {
    logic [COUNT_BITS-1:0] sample_index;
    logic [BAR_BITS-1:0]   bar_length;
    t_sample_class         sample_class;
    t_sample               largest_first;
    t_sample               largest_second;
    t_sample               largest_third;
    t_sample               smallest_first;
    t_sample               smallest_second;
    t_sample               smallest_third;
    logic [COUNT_BITS-1:0] invalid_total;
} t_tracker_stats;

class stats_scoreboard;
    t_sample               big_kept [3];
    t_sample               low_kept [3];
    logic [COUNT_BITS-1:0] seen_total;
    logic [COUNT_BITS-1:0] bad_total;
    logic [LIMIT_BITS-1:0] limit;
    t_tracker_stats        stats_queue [$];
    int                    failures;

    function new();
        for (int k = 0; k < 3; k++) begin
            big_kept[k] = '0;
            low_kept[k] = t_sample'(LOW_RESET);
        end
        seen_total = '0;
        bad_total = '0;
        limit = LIMIT_RESET;
        failures = 0;
    endfunction

    function void set_limit(logic [LIMIT_BITS-1:0] value);
        limit = value;
    endfunction

    function int pending();
        return stats_queue.size();
    endfunction

    function t_sample pick_kept();
        int k;
        k = $urandom_range(0, 5);
        return (k < 3) ? big_kept[k] : low_kept[k - 3];
    endfunction

    function void note_sample(t_sample s);
        t_tracker_stats st;
        int sv;
        int lim;
        sv = s;
        lim = limit;
        if (seen_total != COUNT_MAX) begin
            seen_total++;
        end

        if (s > big_kept[0]) begin
            big_kept[2] = big_kept[1];
            big_kept[1] = big_kept[0];
            big_kept[0] = s;
        end else if (s > big_kept[1]) begin
            big_kept[2] = big_kept[1];
            big_kept[1] = s;
        end else if (s > big_kept[2]) begin
            big_kept[2] = s;
        end

        if (s < low_kept[0]) begin
            low_kept[2] = low_kept[1];
            low_kept[1] = low_kept[0];
            low_kept[0] = s;
        end else if (s < low_kept[1]) begin
            low_kept[2] = low_kept[1];
            low_kept[1] = s;
        end else if (s < low_kept[2]) begin
            low_kept[2] = s;
        end

        if (sv > 0 && sv <= lim) begin
            st.sample_class = CLS_VALID;
            st.bar_length = sv[BAR_BITS-1:0];
        end else if (sv < 0) begin
            st.sample_class = CLS_NEGATIVE;
            sv = -sv;
            st.bar_length = sv[BAR_BITS-1:0];
            if (bad_total != COUNT_MAX) begin
                bad_total++;
            end
        end else if (sv > lim) begin
            st.sample_class = CLS_ABOVE;
            st.bar_length = BAR_BITS'(limit);
            if (bad_total != COUNT_MAX) begin
                bad_total++;
            end
        end else begin
            st.sample_class = CLS_ZERO;
            st.bar_length = '0;
        end

        st.sample_index = seen_total;
        st.largest_first = big_kept[0];
        st.largest_second = big_kept[1];
        st.largest_third = big_kept[2];
        st.smallest_first = low_kept[0];
        st.smallest_second = low_kept[1];
        st.smallest_third = low_kept[2];
        st.invalid_total = bad_total;
        stats_queue.push_back(st);
    endfunction

    function void check_field(string name, integer want, integer got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_stats(t_tracker_stats got);
        t_tracker_stats want;
        if (stats_queue.size() == 0) begin
            $error("result request with no sample outstanding, index %0d", got.sample_index);
            failures++;
            return;
        end
        want = stats_queue.pop_front();
        check_field("sample_index", want.sample_index, got.sample_index);
        check_field("bar_length", want.bar_length, got.bar_length);
        check_field("sample_class", want.sample_class, got.sample_class);
        check_field("largest_first", want.largest_first, got.largest_first);
        check_field("largest_second", want.largest_second, got.largest_second);
        check_field("largest_third", want.largest_third, got.largest_third);
        check_field("smallest_first", want.smallest_first, got.smallest_first);
        check_field("smallest_second", want.smallest_second, got.smallest_second);
        check_field("smallest_third", want.smallest_third, got.smallest_third);
        check_field("invalid_total", want.invalid_total, got.invalid_total);
    endfunction
endclass

module top3_min_max_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = $bits(t_sample);
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 160;
    localparam int TAIL_ITEMS = 200;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady_ready = 1'b0;

    t_sample last_sample = '0;
    stats_scoreboard sb = new();

    int directed_samples [$] = '{
        0, 1, -1, 32767, -32768, 112, 113, 111, 9999, 9999, 10000, 32767,
        -32768, 5, 5, 5, -2, 255, 256, 9998, 0, -9999, 112
    };

    t3mm_cfg_if cfg_if ();
    t3mm_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samp_if ();
    t3mm_result_if #(.SAMPLE_BITS(SAMPLE_W)) res_if ();

    top3_min_max_tracker_top #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg(cfg_if),
        .i_sample(samp_if),
        .o_result(res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_sample gen_sample(input logic [LIMIT_BITS-1:0] lim);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, int'(lim) + 3);
            3: v = -int'($urandom_range(1, 300));
            4: v = 32767 - int'($urandom_range(0, 3));
            5: v = -32768 + int'($urandom_range(0, 3));
            6: v = last_sample;
            7: v = 9998 + int'($urandom_range(0, 2));
            8: v = sb.pick_kept();
            default: v = $urandom();
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_sample gen_invalid(input logic [LIMIT_BITS-1:0] lim);
        int v;
        if ($urandom_range(0, 1) == 0) begin
            v = -int'($urandom_range(1, 32768));
        end else begin
            v = $urandom_range(int'(lim) + 1, 32767);
        end
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input t_sample s);
        samp_if.valid <= 1'b1;
        samp_if.sample <= s;
        do @(posedge i_clk); while (!samp_if.ready);
        sb.note_sample(s);
        last_sample = s;
    endtask

    task automatic sender_idle(input int cycles);
        samp_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 4) == 0) begin
            sender_idle($urandom_range(1, 15));
        end
    endtask

    task automatic drain();
        samp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_limit(value);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        bit gappy;
        gappy = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                gappy = ($urandom_range(0, 2) != 0);
            end
            if (gappy) begin
                maybe_gap();
            end
            send_sample(gen_sample(sb.limit));
        end
    endtask

    always @(posedge i_clk) begin
        t_tracker_stats got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.sample_index = res_if.sample_index;
            got.bar_length = res_if.bar_length;
            got.sample_class = res_if.sample_class;
            got.largest_first = res_if.largest_first;
            got.largest_second = res_if.largest_second;
            got.largest_third = res_if.largest_third;
            got.smallest_first = res_if.smallest_first;
            got.smallest_second = res_if.smallest_second;
            got.smallest_third = res_if.smallest_third;
            got.invalid_total = res_if.invalid_total;
            sb.check_stats(got);
        end
    end

    initial begin
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!steady_ready && $urandom_range(0, 2) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready)
                    || (cfg_if.valid && cfg_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [LIMIT_BITS-1:0] phase_limits [6];
        phase_limits = '{8'd1, 8'd255, 8'd0, 8'd112, 8'd0, 8'd0};
        phase_limits[4] = LIMIT_BITS'($urandom_range(2, 254));
        phase_limits[5] = LIMIT_BITS'($urandom_range(1, 255));

        i_rst_n <= 1'b0;
        samp_if.valid <= 1'b0;
        samp_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_samples[i]) begin
            maybe_gap();
            send_sample(t_sample'(directed_samples[i]));
        end
        drain();

        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            run_random(PHASE_ITEMS);
            drain();
        end

        // The run ends with an unbroken stream of invalid samples and no stalls.
        steady_ready = 1'b1;
        write_limit(LIMIT_BITS'($urandom_range(1, 255)));
        for (int i = 0; i < TAIL_ITEMS; i++) begin
            send_sample(gen_invalid(sb.limit));
        end
        drain();
        repeat (4) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
